// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/itl_pkg.sv =====
`timescale 1ns / 1ps

package itl_pkg;

  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned WIDTH_CFG_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CONSUMED_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_ONLY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd2;

  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 7'd64;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_MAX   = 7'd64;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_WS_PRE  = 10'b00_0000_0010,
    PH_WS_POST = 10'b00_0000_0100,
    PH_DEC     = 10'b00_0000_1000,
    PH_HEXONLY = 10'b00_0001_0000,
    PH_ZERO    = 10'b00_0010_0000,
    PH_ZX      = 10'b00_0100_0000,
    PH_HEXRUN  = 10'b00_1000_0000,
    PH_OCT     = 10'b01_0000_0000,
    PH_TERM    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       space;
    logic       digit;
    logic       xdigit;
    logic       punct;
    logic [3:0] val;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.space  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    r.digit  = (c >= 8'h30 && c <= 8'h39);
    r.xdigit = r.digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    r.punct  = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    if (r.digit) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/integer_text_lexer_unit.sv =====
// Integer text lexer: parses decimal, octal (leading 0) or hex (0x) integers
// from a character stream, one character per input beat.
// Input channel: in_valid / in_stall with in_ch and in_first; in_first = 1
// opens a new token. Output channel: out_valid / out_stall with out_value,
// out_status (0 ok, 1 syntax, 2 overflow) and out_consumed. One output beat
// is produced on the character that ends or rejects a token; all others
// produce none. Config port: cfg_valid / cfg_ready (always ready), cfg_index
// selects width_bits, hex_only or signed_mode; write only while idle.
// Path: input register, then one pass of classify / shift-add / overflow
// compare into the output register. Throughput: one character per cycle
// while in_stall is low, set by the combinational radix shift-add and
// 69-bit compare against the width mask.
// Stall: when the output register holds a beat and out_stall is high, the
// input register, if it holds a character, holds and in_stall rises in the same cycle.
// Reset: clears the token state, empties both registers and restores
// width_bits = 64, hex_only = 0, signed_mode = 0.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module integer_text_lexer_unit #(
  parameter int unsigned COUNT_BITS = itl_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_ch,
  input  logic                                 in_first,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [itl_pkg::VALUE_W-1:0]          out_value,
  output logic [1:0]                           out_status,
  output logic [itl_pkg::CONSUMED_W-1:0]       out_consumed,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [itl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [itl_pkg::WIDTH_CFG_W-1:0]      cfg_data
);

  localparam int unsigned VW = itl_pkg::VALUE_W;
  localparam int unsigned SW = VW + 5;

  logic [itl_pkg::WIDTH_CFG_W-1:0] width_bits_r;
  logic                            hex_only_r;
  logic                            signed_mode_r;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_first_r;

  itl_pkg::phase_t phase_r, phase_nxt;
  logic [VW-1:0]         accum_r, accum_nxt;
  logic                  negative_r, negative_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic                              out_valid_r;
  logic [VW-1:0]                     out_value_r, out_value_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic [itl_pkg::CONSUMED_W-1:0]    out_consumed_r, out_consumed_nxt;

  logic out_free, adv, emit;

  itl_pkg::phase_t       ph_e;
  logic [VW-1:0]         acc_e;
  logic                  neg_e;
  logic [COUNT_BITS-1:0] cnt_e;
  itl_pkg::char_class_t  cc;

  logic [itl_pkg::WIDTH_CFG_W-1:0] w_clamp, w_mag;
  logic [VW-1:0]   mag_max;
  logic [SW-1:0]   shifted, digit_sum;
  logic            ovf;
  logic [4:0]      base;
  logic            inc;
  logic [1:0]      st;
  logic            zero_acc;
  logic [COUNT_BITS+7:0] cnt_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;
  assign out_consumed = out_consumed_r;

  always_comb begin
    if (width_bits_r == '0) begin
      w_clamp = itl_pkg::WIDTH_CFG_W'(1);
    end else if (width_bits_r > itl_pkg::WIDTH_MAX) begin
      w_clamp = itl_pkg::WIDTH_MAX;
    end else begin
      w_clamp = width_bits_r;
    end
    w_mag   = w_clamp - itl_pkg::WIDTH_CFG_W'(signed_mode_r);
    mag_max = ~({VW{1'b1}} << w_mag);
  end

  always_comb begin
    ph_e  = s1_first_r ? itl_pkg::PH_WS_PRE : phase_r;
    acc_e = s1_first_r ? '0 : accum_r;
    neg_e = s1_first_r ? 1'b0 : negative_r;
    cnt_e = s1_first_r ? '0 : count_r;
    cc    = itl_pkg::classify(s1_ch_r);

    priority if (ph_e == itl_pkg::PH_DEC) begin
      base = 5'd10;
    end else if (ph_e == itl_pkg::PH_ZERO || ph_e == itl_pkg::PH_OCT) begin
      base = 5'd8;
    end else if (ph_e == itl_pkg::PH_WS_PRE || ph_e == itl_pkg::PH_WS_POST) begin
      base = hex_only_r ? 5'd16 : 5'd10;
    end else begin
      base = 5'd16;
    end

    unique case (base)
      5'd16:   shifted = {acc_e, 4'b0} + SW'(0);
      5'd8:    shifted = SW'({acc_e, 3'b0});
      default: shifted = SW'({acc_e, 3'b0}) + SW'({acc_e, 1'b0});
    endcase
    digit_sum = shifted + SW'(cc.val);
    ovf       = digit_sum > SW'(mag_max);
  end

  always_comb begin
    phase_nxt    = ph_e;
    accum_nxt    = acc_e;
    negative_nxt = neg_e;
    inc          = 1'b0;
    emit         = 1'b0;
    st           = itl_pkg::ST_OK;
    zero_acc     = 1'b0;

    unique case (ph_e)
      itl_pkg::PH_IDLE: begin
      end
      itl_pkg::PH_WS_PRE, itl_pkg::PH_WS_POST: begin
        if (cc.space) begin
          inc = 1'b1;
        end else if (ph_e == itl_pkg::PH_WS_PRE && signed_mode_r &&
                     s1_ch_r == itl_pkg::CH_MINUS) begin
          negative_nxt = 1'b1;
          inc          = 1'b1;
          phase_nxt    = itl_pkg::PH_WS_POST;
        end else if (hex_only_r) begin
          if (!cc.xdigit) begin
            emit = 1'b1; st = itl_pkg::ST_SYNTAX;
          end else if (ovf) begin
            emit = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            accum_nxt = digit_sum[VW-1:0];
            inc       = 1'b1;
            phase_nxt = itl_pkg::PH_HEXONLY;
          end
        end else if (s1_ch_r == itl_pkg::CH_ZERO) begin
          inc       = 1'b1;
          phase_nxt = itl_pkg::PH_ZERO;
        end else if (cc.digit) begin
          if (ovf) begin
            emit = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            accum_nxt = digit_sum[VW-1:0];
            inc       = 1'b1;
            phase_nxt = itl_pkg::PH_DEC;
          end
        end else begin
          emit = 1'b1; st = itl_pkg::ST_SYNTAX;
        end
      end
      itl_pkg::PH_DEC, itl_pkg::PH_OCT: begin
        if (!cc.digit) begin
          emit = 1'b1;
        end else if (ph_e == itl_pkg::PH_OCT && cc.val >= 4'd8) begin
          emit = 1'b1; st = itl_pkg::ST_SYNTAX;
        end else if (ovf) begin
          emit = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          accum_nxt = digit_sum[VW-1:0];
          inc       = 1'b1;
        end
      end
      itl_pkg::PH_HEXONLY, itl_pkg::PH_HEXRUN: begin
        if (!cc.xdigit) begin
          emit = 1'b1;
        end else if (ovf) begin
          emit = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          accum_nxt = digit_sum[VW-1:0];
          inc       = 1'b1;
        end
      end
      itl_pkg::PH_ZERO: begin
        if (s1_ch_r == itl_pkg::CH_X_LO || s1_ch_r == itl_pkg::CH_X_UP) begin
          inc       = 1'b1;
          phase_nxt = itl_pkg::PH_ZX;
        end else if (s1_ch_r == itl_pkg::CH_ZERO) begin
          inc       = 1'b1;
          phase_nxt = itl_pkg::PH_TERM;
        end else if (cc.digit) begin
          if (cc.val >= 4'd8) begin
            emit = 1'b1; st = itl_pkg::ST_SYNTAX;
          end else if (ovf) begin
            emit = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            accum_nxt = digit_sum[VW-1:0];
            inc       = 1'b1;
            phase_nxt = itl_pkg::PH_OCT;
          end
        end else begin
          emit = 1'b1;
          if (s1_ch_r == itl_pkg::CH_NUL || cc.punct || cc.space) begin
            zero_acc = 1'b1;
          end else begin
            st = itl_pkg::ST_SYNTAX;
          end
        end
      end
      itl_pkg::PH_ZX: begin
        if (s1_ch_r == itl_pkg::CH_ZERO) begin
          inc       = 1'b1;
          phase_nxt = itl_pkg::PH_TERM;
        end else if (!cc.xdigit) begin
          emit = 1'b1;
        end else if (ovf) begin
          emit = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          accum_nxt = digit_sum[VW-1:0];
          inc       = 1'b1;
          phase_nxt = itl_pkg::PH_HEXRUN;
        end
      end
      itl_pkg::PH_TERM: begin
        emit = 1'b1;
        if (s1_ch_r == itl_pkg::CH_NUL || cc.punct || cc.space) begin
          zero_acc = 1'b1;
        end else begin
          st = itl_pkg::ST_SYNTAX;
        end
      end
      default: begin
        phase_nxt = itl_pkg::PH_IDLE;
      end
    endcase

    if (zero_acc) begin
      accum_nxt = '0;
    end
    if (emit) begin
      phase_nxt = itl_pkg::PH_IDLE;
    end

    if (inc && cnt_e != '1) begin
      count_nxt = cnt_e + COUNT_BITS'(1);
    end else begin
      count_nxt = cnt_e;
    end

    cnt_ext        = {8'b0, cnt_e};
    out_status_nxt = st;
    if (st == itl_pkg::ST_OK) begin
      out_value_nxt    = neg_e ? (VW'(0) - accum_nxt) : accum_nxt;
      out_consumed_nxt = (cnt_ext > (COUNT_BITS+8)'(255)) ? 8'hFF : cnt_ext[7:0];
    end else begin
      out_value_nxt    = '0;
      out_consumed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_bits_r  <= itl_pkg::WIDTH_RESET;
      hex_only_r    <= 1'b0;
      signed_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        itl_pkg::CFG_WIDTH_BITS:  width_bits_r  <= cfg_data;
        itl_pkg::CFG_HEX_ONLY:    hex_only_r    <= cfg_data[0];
        itl_pkg::CFG_SIGNED_MODE: signed_mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_ch_r    <= in_ch;
      s1_first_r <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= itl_pkg::PH_IDLE;
      accum_r    <= '0;
      negative_r <= 1'b0;
      count_r    <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      negative_r <= negative_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv && emit) begin
      out_value_r    <= out_value_nxt;
      out_status_r   <= out_status_nxt;
      out_consumed_r <= out_consumed_nxt;
    end
  end

  `ASSERT_SAME(a_reject_zero,
    out_valid_r && out_status_r != itl_pkg::ST_OK,
    out_value_r == '0 && out_consumed_r == '0)
  `ASSERT_SAME(a_stall_cause,
    in_stall,
    s1_valid_r && out_valid_r && out_stall)
  `ASSERT_NEXT(a_emit_idle,
    adv && emit,
    phase_r == itl_pkg::PH_IDLE && out_valid_r)

endmodule

// ===== tb/tb_integer_text_lexer_unit.sv =====
`timescale 1ns / 1ps

module tb_integer_text_lexer_unit;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_beat_t;

  typedef struct packed {
    logic [itl_pkg::VALUE_W-1:0]    value;
    logic [1:0]                     status;
    logic [itl_pkg::CONSUMED_W-1:0] consumed;
  } lex_result_t;

  localparam int CNT_W             = itl_pkg::COUNT_BITS_DEF;
  localparam int N_SETTINGS        = 15;
  localparam int ITEMS_PER_SETTING = 90;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_ch        = '0;
  logic                            in_first     = 1'b0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic [itl_pkg::VALUE_W-1:0]     out_value;
  logic [1:0]                      out_status;
  logic [itl_pkg::CONSUMED_W-1:0]  out_consumed;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [itl_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
  logic [itl_pkg::WIDTH_CFG_W-1:0] cfg_data     = '0;

  integer_text_lexer_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_status   (out_status),
    .out_consumed (out_consumed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and token state
  logic [itl_pkg::WIDTH_CFG_W-1:0] cfg_width  = itl_pkg::WIDTH_RESET;
  bit                              cfg_hex    = 1'b0;
  bit                              cfg_signed = 1'b0;
  itl_pkg::phase_t                 tok_phase  = itl_pkg::PH_IDLE;
  logic [63:0]                     tok_accum  = '0;
  bit                              tok_neg    = 1'b0;
  logic [CNT_W-1:0]                tok_count  = '0;

  char_beat_t  pending_chars[$];
  lex_result_t expected_tokens[$];
  char_beat_t  next_beat;
  lex_result_t predicted;
  lex_result_t want;
  logic        in_took = 1'b0;
  bit          gen_first;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          fed_items      = 0;
  int          chars_lexed    = 0;
  int          mismatches     = 0;
  int          n_ok           = 0;
  int          n_syntax       = 0;
  int          n_ovf          = 0;
  int          n_saturated    = 0;

  int set_w [N_SETTINGS] = '{64, 64, 64, 64, 32, 8, 16, 1, 1, 2, 0, 127, 33, 7, 64};
  bit set_h [N_SETTINGS] = '{0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0};
  bit set_s [N_SETTINGS] = '{0, 1, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0};

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic bit is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [63:0] hex_val(logic [7:0] c);
    if (is_digit(c)) return 64'(c - "0");
    if (c >= "a" && c <= "f") return 64'(c - "a" + 8'd10);
    return 64'(c - "A" + 8'd10);
  endfunction

  function automatic logic [63:0] mag_limit();
    int w;
    w = int'(cfg_width);
    if (w == 0) w = 1;
    if (w > 64) w = 64;
    if (cfg_signed) w = w - 1;
    if (w == 0) return 64'd0;
    return {64{1'b1}} >> (64 - w);
  endfunction

  function automatic bit digit_overflows(logic [63:0] base, logic [63:0] d);
    logic [63:0] mx;
    logic [63:0] m;
    mx = mag_limit();
    if (tok_accum > mx / base) return 1'b1;
    m = tok_accum * base;
    if (mx - m < d) return 1'b1;
    tok_accum = m + d;
    return 1'b0;
  endfunction

  function automatic void bump_count();
    if (tok_count != {CNT_W{1'b1}}) tok_count = tok_count + 1'b1;
  endfunction

  // lone zero forms end cleanly only on NUL, punctuation or whitespace
  function automatic logic [1:0] zero_tail_status(logic [7:0] c);
    if (c == itl_pkg::CH_NUL || is_punct(c) || is_space(c)) begin
      tok_accum = '0;
      return itl_pkg::ST_OK;
    end
    return itl_pkg::ST_SYNTAX;
  endfunction

  function automatic bit lex_char(input logic [7:0] c, input bit first,
                                  output lex_result_t r);
    bit         done;
    logic [1:0] st;
    r = '0;
    done = 1'b0;
    st = itl_pkg::ST_OK;
    if (first) begin
      tok_phase = itl_pkg::PH_WS_PRE;
      tok_accum = '0;
      tok_neg = 1'b0;
      tok_count = '0;
    end else if (tok_phase == itl_pkg::PH_IDLE) begin
      return 1'b0;
    end
    case (tok_phase)
      itl_pkg::PH_WS_PRE, itl_pkg::PH_WS_POST: begin
        if (is_space(c)) begin
          bump_count();
        end else if (tok_phase == itl_pkg::PH_WS_PRE && cfg_signed &&
                     c == itl_pkg::CH_MINUS) begin
          tok_neg = 1'b1;
          bump_count();
          tok_phase = itl_pkg::PH_WS_POST;
        end else if (cfg_hex) begin
          if (!is_xdigit(c)) begin
            done = 1'b1; st = itl_pkg::ST_SYNTAX;
          end else if (digit_overflows(64'd16, hex_val(c))) begin
            done = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            bump_count();
            tok_phase = itl_pkg::PH_HEXONLY;
          end
        end else if (c == itl_pkg::CH_ZERO) begin
          bump_count();
          tok_phase = itl_pkg::PH_ZERO;
        end else if (is_digit(c)) begin
          if (digit_overflows(64'd10, 64'(c - itl_pkg::CH_ZERO))) begin
            done = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            bump_count();
            tok_phase = itl_pkg::PH_DEC;
          end
        end else begin
          done = 1'b1; st = itl_pkg::ST_SYNTAX;
        end
      end
      itl_pkg::PH_DEC: begin
        if (!is_digit(c)) begin
          done = 1'b1;
        end else if (digit_overflows(64'd10, 64'(c - itl_pkg::CH_ZERO))) begin
          done = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          bump_count();
        end
      end
      itl_pkg::PH_HEXONLY, itl_pkg::PH_HEXRUN: begin
        if (!is_xdigit(c)) begin
          done = 1'b1;
        end else if (digit_overflows(64'd16, hex_val(c))) begin
          done = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          bump_count();
        end
      end
      itl_pkg::PH_ZERO: begin
        if (c == itl_pkg::CH_X_LO || c == itl_pkg::CH_X_UP) begin
          bump_count();
          tok_phase = itl_pkg::PH_ZX;
        end else if (c == itl_pkg::CH_ZERO) begin
          bump_count();
          tok_phase = itl_pkg::PH_TERM;
        end else if (is_digit(c)) begin
          if (c - itl_pkg::CH_ZERO >= 8'd8) begin
            done = 1'b1; st = itl_pkg::ST_SYNTAX;
          end else if (digit_overflows(64'd8, 64'(c - itl_pkg::CH_ZERO))) begin
            done = 1'b1; st = itl_pkg::ST_OVF;
          end else begin
            bump_count();
            tok_phase = itl_pkg::PH_OCT;
          end
        end else begin
          done = 1'b1; st = zero_tail_status(c);
        end
      end
      itl_pkg::PH_ZX: begin
        if (c == itl_pkg::CH_ZERO) begin
          bump_count();
          tok_phase = itl_pkg::PH_TERM;
        end else if (!is_xdigit(c)) begin
          done = 1'b1;
        end else if (digit_overflows(64'd16, hex_val(c))) begin
          done = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          bump_count();
          tok_phase = itl_pkg::PH_HEXRUN;
        end
      end
      itl_pkg::PH_OCT: begin
        if (!is_digit(c)) begin
          done = 1'b1;
        end else if (c - itl_pkg::CH_ZERO >= 8'd8) begin
          done = 1'b1; st = itl_pkg::ST_SYNTAX;
        end else if (digit_overflows(64'd8, 64'(c - itl_pkg::CH_ZERO))) begin
          done = 1'b1; st = itl_pkg::ST_OVF;
        end else begin
          bump_count();
        end
      end
      itl_pkg::PH_TERM: begin
        done = 1'b1; st = zero_tail_status(c);
      end
      default: begin
        tok_phase = itl_pkg::PH_IDLE;
      end
    endcase
    if (done) begin
      r.status = st;
      if (st == itl_pkg::ST_OK) begin
        r.value = tok_neg ? 64'd0 - tok_accum : tok_accum;
        r.consumed = (tok_count > 255) ? 8'hFF : 8'(tok_count);
      end
      tok_phase = itl_pkg::PH_IDLE;
    end
    return done;
  endfunction

  function automatic void report_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // driver: a held beat stays until accepted
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_beat = pending_chars.pop_front();
        in_ch <= next_beat.ch;
        in_first <= next_beat.first;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        chars_lexed++;
        if (lex_char(in_ch, in_first, predicted)) begin
          expected_tokens.push_back(predicted);
          if (predicted.status == itl_pkg::ST_OK) n_ok++;
          else if (predicted.status == itl_pkg::ST_SYNTAX) n_syntax++;
          else n_ovf++;
          if (predicted.status == itl_pkg::ST_OK && predicted.consumed == 8'hFF)
            n_saturated++;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_error($sformatf("unexpected beat: value %h status %0d consumed %0d",
                                 out_value, out_status, out_consumed));
        end else begin
          want = expected_tokens.pop_front();
          if (out_value !== want.value || out_status !== want.status ||
              out_consumed !== want.consumed) begin
            report_error($sformatf(
              "mismatch: exp value %h status %0d consumed %0d, got value %h status %0d consumed %0d",
              want.value, want.status, want.consumed, out_value, out_status, out_consumed));
          end
        end
      end
    end
  end

  task automatic push_beat(logic [7:0] c, bit f, bit counted);
    char_beat_t b;
    b.ch = c;
    b.first = f;
    pending_chars.push_back(b);
    if (counted) fed_items++;
  endtask

  task automatic push_char(logic [7:0] c);
    push_beat(c, gen_first, 1'b1);
    gen_first = 1'b0;
  endtask

  task automatic push_text(string s, bit open);
    gen_first = open;
    for (int i = 0; i < s.len(); i++) push_char(s.getc(i));
  endtask

  function automatic logic [7:0] rand_space();
    if ($urandom_range(1) == 0) return 8'd32;
    return 8'($urandom_range(13, 9));
  endfunction

  function automatic logic [7:0] rand_stop();
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = itl_pkg::CH_NUL;
      1: c = rand_space();
      2: begin
        do c = 8'($urandom_range(126, 33)); while (!is_punct(c));
      end
      3: c = 8'($urandom_range(255));
      4: c = 8'($urandom_range(255, 128));
      default: c = 8'("g" + $urandom_range(19));
    endcase
    return c;
  endfunction

  task automatic push_number();
    logic [63:0] mx;
    logic [63:0] v;
    string       s;
    mx = mag_limit();
    case ($urandom_range(7))
      0: v = mx;
      1: v = mx + 64'd1;
      2: v = 64'($urandom_range(9));
      3, 4: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = {$urandom, $urandom} & mx;
    endcase
    if (cfg_hex) begin
      s = $sformatf("%0h", v);
      if ($urandom_range(5) == 0) s = {"00", s};
    end else begin
      case ($urandom_range(6))
        0, 1, 2: s = $sformatf("%0d", v);
        3: s = {"0", $sformatf("%0o", v)};
        4, 5: begin
          if ($urandom_range(1) == 0) s = {"0x", $sformatf("%0h", v)};
          else s = {"0X", $sformatf("%0h", v)};
        end
        default: begin
          case ($urandom_range(4))
            0: s = "0";
            1: s = "00";
            2: s = "0x0";
            3: s = "0X0";
            default: s = "0x";
          endcase
        end
      endcase
    end
    for (int i = 0; i < s.len(); i++) begin
      if (s.getc(i) >= "a" && s.getc(i) <= "f" && $urandom_range(1) == 1)
        s.putc(i, s.getc(i) - 8'd32);
    end
    if ($urandom_range(9) == 0) s.putc($urandom_range(s.len() - 1), 8'("0" + $urandom_range(9)));
    if ($urandom_range(7) == 0) s = {s, $sformatf("%0d", $urandom_range(9))};
    for (int i = 0; i < s.len(); i++) push_char(s.getc(i));
  endtask

  task automatic push_token();
    int n;
    gen_first = 1'b1;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++)
        push_beat(8'($urandom_range(255)), i == 0 || $urandom_range(7) == 0, 1'b1);
      return;
    end
    n = $urandom_range(2);
    for (int i = 0; i < n; i++) push_char(rand_space());
    if (cfg_signed ? $urandom_range(2) != 0 : $urandom_range(9) == 0) begin
      push_char(itl_pkg::CH_MINUS);
      if ($urandom_range(11) == 0) push_char(itl_pkg::CH_MINUS);
      n = $urandom_range(1);
      for (int i = 0; i < n; i++) push_char(rand_space());
    end
    push_number();
    if ($urandom_range(6) != 0) push_char(rand_stop());
    if ($urandom_range(6) == 0) push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  // close any open token, drain, and let the pipeline empty
  task automatic settle();
    push_beat("g", 1'b1, 1'b0);
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [itl_pkg::CFG_IDX_W-1:0] idx,
                           logic [itl_pkg::WIDTH_CFG_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      itl_pkg::CFG_WIDTH_BITS:  cfg_width = d;
      itl_pkg::CFG_HEX_ONLY:    cfg_hex = d[0];
      itl_pkg::CFG_SIGNED_MODE: cfg_signed = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [itl_pkg::WIDTH_CFG_W-1:0] w, bit h, bit s);
    write_reg(itl_pkg::CFG_WIDTH_BITS, w);
    write_reg(itl_pkg::CFG_HEX_ONLY, itl_pkg::WIDTH_CFG_W'(h));
    write_reg(itl_pkg::CFG_SIGNED_MODE, itl_pkg::WIDTH_CFG_W'(s));
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, 8-bit unsigned auto-detect
    apply_setting(7'd8, 1'b0, 1'b0);
    push_text("255 ", 1'b1);
    push_text("256", 1'b1);
    push_text("0x0;", 1'b1);
    push_text("0xg", 1'b1);
    push_text("09", 1'b1);
    push_text("07", 1'b1);
    push_char(itl_pkg::CH_NUL);
    push_text("A", 1'b0);
    push_text("\t1", 1'b1);
    push_beat(8'd200, 1'b1, 1'b1);
    push_text("-", 1'b1);
    // long leading whitespace drives the count into saturation
    gen_first = 1'b1;
    for (int i = 0; i < 258; i++) push_char(8'd32);
    push_text("7 ", 1'b0);
    settle();

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k == N_SETTINGS - 1)
        apply_setting(7'($urandom_range(127)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        apply_setting(7'(set_w[k]), set_h[k], set_s[k]);
      case (k % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
        default: begin send_gap_pct = 13; recv_stall_pct = 13; end
      endcase
      target = fed_items + ITEMS_PER_SETTING / 2;
      while (fed_items < target) push_token();
      wait_drained();
      target = fed_items + ITEMS_PER_SETTING / 2;
      while (fed_items < target) push_token();
      settle();
    end

    repeat (10) @(posedge clk);
    $display("%0d characters lexed over %0d register settings plus directed tokens",
             chars_lexed, N_SETTINGS);
    $display("token results: %0d ok (%0d with saturated count), %0d syntax, %0d overflow",
             n_ok, n_saturated, n_syntax, n_ovf);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
